>>> design/mexp_pkg.sv
// Shared constants for the modular exponentiation block.
`timescale 1ns / 1ps
package mexp_pkg;

	// default operand width of the arithmetic datapath
	localparam int MEXP_WIDTH = 32;

	// width of the value, result and configuration data ports
	localparam int FIELD_W = 32;

	// configuration register index
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

endpackage

>>> design/mexp_mulmod.sv
// Shared bit-serial modular multiplier: prod = a * b mod n, one bit of b per cycle.
`timescale 1ns / 1ps
module mexp_mulmod import mexp_pkg::*; #(
	parameter int WIDTH = MEXP_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] n,
	output logic             done,
	output logic [WIDTH-1:0] prod
);

	localparam int CNT_W = $clog2(WIDTH);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] r_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] n_q;

	logic [WIDTH+1:0] sum;
	logic [WIDTH+1:0] n1;
	logic [WIDTH+1:0] n2;
	logic [WIDTH-1:0] r_next;

	// one step: 2r + a*bit lies below 3n, so take off 0, n or 2n
	always_comb begin
		sum = {1'b0, r_q, 1'b0} + (b_q[WIDTH-1] ? {2'b00, a_q} : '0);
		n1  = {2'b00, n_q};
		n2  = {1'b0, n_q, 1'b0};
		if (sum >= n2) begin
			r_next = WIDTH'(sum - n2);
		end else if (sum >= n1) begin
			r_next = WIDTH'(sum - n1);
		end else begin
			r_next = WIDTH'(sum);
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= LAST;
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// operands and partial remainder
	always_ff @(posedge clk) begin
		if (go) begin
			r_q <= '0;
			a_q <= a;
			b_q <= b;
			n_q <= n;
		end else if (run_q) begin
			r_q <= r_next;
			b_q <= b_q << 1;
		end
	end

	assign done = done_q;
	assign prod = r_q;

endmodule

>>> design/mexp_ctrl.sv
// Square-and-multiply sequencer driving the shared modular multiplier.
`timescale 1ns / 1ps
module mexp_ctrl import mexp_pkg::*; #(
	parameter int WIDTH = MEXP_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [WIDTH-1:0]   value,
	input  logic [WIDTH-1:0]   exponent,
	input  logic [WIDTH-1:0]   modulus,
	output logic               busy,
	output logic               done,
	output logic [FIELD_W-1:0] result,
	output logic               mm_go,
	output logic [WIDTH-1:0]   mm_a,
	output logic [WIDTH-1:0]   mm_b,
	output logic [WIDTH-1:0]   mm_n,
	input  logic               mm_done,
	input  logic [WIDTH-1:0]   mm_prod
);

	localparam int CNT_W = $clog2(WIDTH);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RED  = 2'd1;
	localparam logic [1:0] ST_SQR  = 2'd2;
	localparam logic [1:0] ST_MUL  = 2'd3;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   bit_q;
	logic [WIDTH-1:0]   exp_q;
	logic [WIDTH-1:0]   mod_q;
	logic [WIDTH-1:0]   base_q;
	logic               done_q;
	logic [FIELD_W-1:0] result_q;

	logic               last_bit;
	logic               exp_bit;
	logic [WIDTH-1:0]   acc_init;

	assign last_bit = (bit_q == '0);
	assign exp_bit  = exp_q[bit_q];
	// 1 mod n: zero only for a modulus of one
	assign acc_init = (mod_q == WIDTH'(1)) ? '0 : WIDTH'(1);

	// next multiplier job, issued on start or in the cycle the previous one finishes
	always_comb begin
		mm_go = 1'b0;
		mm_a  = mm_prod;
		mm_b  = mm_prod;
		mm_n  = mod_q;
		case (state_q)
			ST_IDLE: begin
				// reduce the input word: 1 * value mod n
				mm_a = WIDTH'(1);
				mm_b = value;
				mm_n = modulus;
				mm_go = start && (exponent != '0) && (modulus != '0);
			end
			ST_RED: begin
				mm_a  = acc_init;
				mm_b  = acc_init;
				mm_go = mm_done;
			end
			ST_SQR: begin
				if (exp_bit) begin
					mm_b  = base_q;
					mm_go = mm_done;
				end else begin
					mm_go = mm_done && !last_bit;
				end
			end
			ST_MUL: begin
				mm_go = mm_done && !last_bit;
			end
			default: begin
				mm_go = 1'b0;
			end
		endcase
	end

	// sequencer, exponent scanned from the top bit down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bit_q    <= '0;
			exp_q    <= '0;
			mod_q    <= '0;
			base_q   <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						exp_q <= exponent;
						mod_q <= modulus;
						if (exponent == '0) begin
							done_q   <= 1'b1;
							result_q <= FIELD_W'(1);
						end else if (modulus == '0) begin
							done_q   <= 1'b1;
							result_q <= '0;
						end else begin
							state_q <= ST_RED;
						end
					end
				end
				ST_RED: begin
					if (mm_done) begin
						base_q  <= mm_prod;
						bit_q   <= LAST;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (mm_done) begin
						if (exp_bit) begin
							state_q <= ST_MUL;
						end else if (last_bit) begin
							done_q   <= 1'b1;
							result_q <= FIELD_W'(mm_prod);
							state_q  <= ST_IDLE;
						end else begin
							bit_q <= bit_q - CNT_W'(1);
						end
					end
				end
				ST_MUL: begin
					if (mm_done) begin
						if (last_bit) begin
							done_q   <= 1'b1;
							result_q <= FIELD_W'(mm_prod);
							state_q  <= ST_IDLE;
						end else begin
							bit_q   <= bit_q - CNT_W'(1);
							state_q <= ST_SQR;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

>>> design/modular_exponentiation.sv
// Modular exponentiation top level: result = value ^ exponent mod modulus.
//
// Use: write exponent (index 0) and modulus (index 1) through the cfg channel
// while the block is idle; a write transfers when cfg_valid and cfg_ready are
// both high (cfg_ready is always high). Unknown indexes are ignored.
// Start an item by raising start with value while busy is low. The answer
// appears on result, marked by done for exactly one cycle; the receiver must
// take it then, there is no back-pressure.
// One shared bit-serial multiplier does all the work: an item takes one
// modular product to reduce value, one square per exponent bit (WIDTH)
// and one multiply per one in the exponent. A zero exponent answers 1 and
// a zero modulus answers 0, both in the cycle after start.
// One item at a time: busy stays high until the result is delivered.
// Reset: exponent and modulus return to 1, the sequencer goes idle and no
// result is pending.
`timescale 1ns / 1ps
module modular_exponentiation import mexp_pkg::*; #(
	parameter int WIDTH = MEXP_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [FIELD_W-1:0]   value,
	output logic                 busy,
	output logic                 done,
	output logic [FIELD_W-1:0]   result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data
);

	logic [WIDTH-1:0] exponent_q;
	logic [WIDTH-1:0] modulus_q;

	logic             mm_go;
	logic [WIDTH-1:0] mm_a;
	logic [WIDTH-1:0] mm_b;
	logic [WIDTH-1:0] mm_n;
	logic             mm_done;
	logic [WIDTH-1:0] mm_prod;

	assign cfg_ready = 1'b1;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= WIDTH'(1);
			modulus_q  <= WIDTH'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EXPONENT: exponent_q <= WIDTH'(cfg_data);
				REG_MODULUS:  modulus_q  <= WIDTH'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	mexp_ctrl #(
		.WIDTH(WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.value    (WIDTH'(value)),
		.exponent (exponent_q),
		.modulus  (modulus_q),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.mm_go    (mm_go),
		.mm_a     (mm_a),
		.mm_b     (mm_b),
		.mm_n     (mm_n),
		.mm_done  (mm_done),
		.mm_prod  (mm_prod)
	);

	mexp_mulmod #(
		.WIDTH(WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mm_go),
		.a      (mm_a),
		.b      (mm_b),
		.n      (mm_n),
		.done   (mm_done),
		.prod   (mm_prod)
	);

endmodule
